// File: rtl/core/utf8d_pkg.sv
// Shared widths, constants and types of the UTF-8 decoder.
package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W = 21;
    localparam int PART_W = 15;
    localparam int PEND_W = 2;
    localparam int CONT_W = 6;
    localparam int QDEPTH = 3;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 2;
    localparam int PUSH_W = 2;

    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    localparam logic [PUSH_W-1:0] PUSH_NONE = 2'd0;
    localparam logic [PUSH_W-1:0] PUSH_ONE = 2'd1;
    localparam logic [PUSH_W-1:0] PUSH_TWO = 2'd2;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_error;
        logic            last;
    } t_result;

    typedef struct packed {
        logic [PUSH_W-1:0] count;
        t_result           res0;
        t_result           res1;
    } t_push;

endpackage

// File: rtl/core/utf8d_ifs.sv
// Byte and code point channel interfaces of the UTF-8 decoder.
interface utf8d_byte_if import utf8d_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source(output valid, output in_byte, input ready);
    modport sink(input valid, input in_byte, output ready);
endinterface

interface utf8d_cp_if import utf8d_pkg::*;;
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            is_error;
    logic            last;

    modport source(output valid, output code_point, output is_error, output last, input ready);
    modport sink(input valid, input code_point, input is_error, input last, output ready);
endinterface

// File: rtl/core/utf8d_step.sv
// Decode of one byte against the open sequence state, giving up to two results.
module utf8d_step import utf8d_pkg::*; (
    input  logic [PEND_W-1:0] i_pend,
    input  logic [PART_W-1:0] i_part,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [PEND_W-1:0] o_pend,
    output logic [PART_W-1:0] o_part,
    output t_push             o_push
);

    logic              lead_emit;
    logic              lead_err;
    logic [PEND_W-1:0] lead_pend;
    logic [PART_W-1:0] lead_part;
    logic              is_cont;
    logic [CP_W-1:0]   cont_v;
    t_result           lead_res;
    t_result           err_res;

    always_comb begin
        lead_emit = 1'b0;
        lead_err = 1'b0;
        lead_pend = PEND_NONE;
        lead_part = '0;
        if (!i_byte[7]) begin
            lead_emit = 1'b1;
        end else if (!i_byte[6]) begin
            lead_emit = 1'b1;
            lead_err = 1'b1;
        end else if (!i_byte[5]) begin
            lead_pend = PEND_ONE;
            lead_part = PART_W'(i_byte & LEAD2_MASK);
        end else if (!i_byte[4]) begin
            lead_pend = PEND_TWO;
            lead_part = PART_W'(i_byte & LEAD3_MASK);
        end else if (!i_byte[3]) begin
            lead_pend = PEND_THREE;
            lead_part = PART_W'(i_byte & LEAD4_MASK);
        end else begin
            lead_emit = 1'b1;
            lead_err = 1'b1;
        end
    end

    assign is_cont = ((i_byte & CONT_MASK) == CONT_TAG);
    assign cont_v = {i_part, i_byte[CONT_W-1:0]};

    always_comb begin
        lead_res.code_point = lead_err ? '0 : CP_W'(i_byte);
        lead_res.is_error = lead_err;
        lead_res.last = 1'b1;
        err_res.code_point = '0;
        err_res.is_error = 1'b1;
        err_res.last = 1'b1;
    end

    always_comb begin
        o_pend = lead_pend;
        o_part = lead_part;
        o_push.count = PUSH_NONE;
        o_push.res0 = lead_res;
        o_push.res1 = lead_res;
        if (i_pend != PEND_NONE) begin
            if (is_cont) begin
                o_pend = i_pend - PEND_W'(1);
                if (i_pend == PEND_ONE) begin
                    o_part = '0;
                    o_push.count = PUSH_ONE;
                    o_push.res0.code_point = cont_v;
                    o_push.res0.is_error = 1'b0;
                    o_push.res0.last = 1'b1;
                end else begin
                    o_part = cont_v[PART_W-1:0];
                end
            end else begin
                o_push.res0 = err_res;
                if (lead_emit) begin
                    o_push.count = PUSH_TWO;
                    o_push.res0.last = 1'b0;
                end else begin
                    o_push.count = PUSH_ONE;
                end
            end
        end else if (lead_emit) begin
            o_push.count = PUSH_ONE;
        end
    end

endmodule

// File: rtl/core/utf8d_rqueue.sv
// Three-entry result queue that takes up to two results per cycle.
module utf8d_rqueue import utf8d_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_push        i_push,
    output logic         o_space,
    utf8d_cp_if.source   o_out
);

    t_result             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wptr;
    logic [QPTR_W-1:0]   n_rptr;
    logic [QCNT_W-1:0]   n_count;
    logic [QPTR_W-1:0]   wptr_1;
    logic                pop;
    t_result             head;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_space = (r_count <= QCNT_W'(1));
    assign pop = o_out.valid && o_out.ready;
    assign wptr_1 = ptr_inc(r_wptr);

    always_comb begin
        n_wptr = r_wptr;
        case (i_push.count)
            PUSH_ONE: n_wptr = wptr_1;
            PUSH_TWO: n_wptr = ptr_inc(wptr_1);
            default:  n_wptr = r_wptr;
        endcase
        n_rptr = pop ? ptr_inc(r_rptr) : r_rptr;
        n_count = r_count + QCNT_W'(i_push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != PUSH_NONE) begin
            r_mem[r_wptr] <= i_push.res0;
        end
        if (i_push.count == PUSH_TWO) begin
            r_mem[wptr_1] <= i_push.res1;
        end
    end

    assign head = r_mem[r_rptr];
    assign o_out.valid = (r_count != '0);
    assign o_out.code_point = head.code_point;
    assign o_out.is_error = head.is_error;
    assign o_out.last = head.last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("Result queue count exceeds its depth.");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != PUSH_NONE) |-> o_space)
        else $error("Results pushed into a queue without room.");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wptr == r_rptr))
        else $error("Empty queue with pointers apart.");

endmodule

// File: rtl/core/utf8_lenient_decoder.sv
// Top level of the lenient UTF-8 decoder: byte channel in, code point channel out.
//
//  Channel  Direction  Payload                         Transfer when
//  i_in     in         in_byte[7:0]                    i_in.valid & i_in.ready
//  o_out    out        code_point[20:0], is_error, last o_out.valid & o_out.ready
//
// Each byte is decoded in the cycle of its transfer and its results enter a
// three-entry result queue, so one byte can be taken every cycle while the
// queue has room. A byte that ends a cut-short sequence gives an error result
// and, unless it opens a new sequence, its own result as well; i_in.ready is
// high while the queue holds at most one result. Synchronous active-low reset
// empties the queue and closes any open sequence.
module utf8_lenient_decoder import utf8d_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utf8d_byte_if.sink    i_in,
    utf8d_cp_if.source    o_out
);

    logic [PEND_W-1:0] r_pend;
    logic [PART_W-1:0] r_part;
    logic [PEND_W-1:0] n_pend;
    logic [PART_W-1:0] n_part;
    t_push             step_push;
    t_push             n_push;
    logic              q_space;
    logic              accept;

    utf8d_step u_step (
        .i_pend (r_pend),
        .i_part (r_part),
        .i_byte (i_in.in_byte),
        .o_pend (n_pend),
        .o_part (n_part),
        .o_push (step_push)
    );

    assign i_in.ready = q_space;
    assign accept = i_in.valid && i_in.ready;

    always_comb begin
        n_push = step_push;
        if (!accept) begin
            n_push.count = PUSH_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= PEND_NONE;
            r_part <= '0;
        end else if (accept) begin
            r_pend <= n_pend;
            r_part <= n_part;
        end
    end

    utf8d_rqueue u_rqueue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_push),
        .o_space (q_space),
        .o_out   (o_out)
    );

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_error) |-> (o_out.code_point == '0))
        else $error("Error result carries a nonzero code point.");

    a_part_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == PEND_THREE) |-> (r_part[PART_W-1:3] == '0))
        else $error("Four-byte lead left too many payload bits.");

    a_part_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == PEND_TWO) |-> (r_part[PART_W-1:10] == '0))
        else $error("Open sequence holds too many payload bits.");

    a_idle_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == PEND_NONE) |-> (r_part == '0))
        else $error("Payload bits kept with no sequence open.");

endmodule

// File: tb/sv/utf8_lenient_decoder_chk.sv
// Checker of the lenient UTF-8 decoder: decodes transferred bytes and compares the code points, error and last flags.
module utf8_lenient_decoder_chk import utf8d_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    utf8d_byte_if i_in,
    utf8d_cp_if   i_out,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PEND_W-1:0] seq_left;
    logic [PART_W-1:0] seq_bits;
    t_result           cp_expect_q[$];
    int                fails = 0;
    int                mismatches = 0;

    function automatic void push_cp(logic [CP_W-1:0] cp, logic err);
        t_result r;
        r.code_point = cp;
        r.is_error = err;
        r.last = 1'b0;
        cp_expect_q.push_back(r);
    endfunction

    function automatic void start_byte(logic [BYTE_W-1:0] b);
        if (!b[7]) begin
            push_cp(CP_W'(b), 1'b0);
        end else if (!b[6]) begin
            push_cp('0, 1'b1);
        end else if (!b[5]) begin
            seq_left = PEND_ONE;
            seq_bits = PART_W'(b & LEAD2_MASK);
        end else if (!b[4]) begin
            seq_left = PEND_TWO;
            seq_bits = PART_W'(b & LEAD3_MASK);
        end else if (!b[3]) begin
            seq_left = PEND_THREE;
            seq_bits = PART_W'(b & LEAD4_MASK);
        end else begin
            push_cp('0, 1'b1);
        end
    endfunction

    function automatic void decode_byte(logic [BYTE_W-1:0] b);
        int              queued;
        logic [CP_W-1:0] acc;
        queued = cp_expect_q.size();
        if (seq_left != PEND_NONE) begin
            if ((b & CONT_MASK) == CONT_TAG) begin
                acc = {seq_bits, b[CONT_W-1:0]};
                seq_left = seq_left - PEND_W'(1);
                if (seq_left == PEND_NONE) begin
                    seq_bits = '0;
                    push_cp(acc, 1'b0);
                end else begin
                    seq_bits = acc[PART_W-1:0];
                end
            end else begin
                seq_left = PEND_NONE;
                seq_bits = '0;
                push_cp('0, 1'b1);
                start_byte(b);
            end
        end else begin
            start_byte(b);
        end
        if (cp_expect_q.size() > queued) begin
            cp_expect_q[cp_expect_q.size() - 1].last = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            seq_left = PEND_NONE;
            seq_bits = '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                decode_byte(i_in.in_byte);
            end
            if (i_out.valid && i_out.ready) begin
                got.code_point = i_out.code_point;
                got.is_error = i_out.is_error;
                got.last = i_out.last;
                if (cp_expect_q.size() == 0) begin
                    fails++;
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result cp=%h err=%b last=%b",
                                 $realtime, got.code_point, got.is_error, got.last);
                    end
                end else begin
                    want = cp_expect_q.pop_front();
                    if (got.code_point !== want.code_point || got.is_error !== want.is_error
                            || got.last !== want.last) begin
                        fails++;
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: mismatch expected cp=%h err=%b last=%b,",
                                      " got cp=%h err=%b last=%b"},
                                     $realtime, want.code_point, want.is_error, want.last,
                                     got.code_point, got.is_error, got.last);
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= cp_expect_q.size();
    end

endmodule

// File: tb/sv/utf8_lenient_decoder_tb.sv
// Testbench top of the lenient UTF-8 decoder: clock, reset, byte stimulus and verdict.
module utf8_lenient_decoder_tb import utf8d_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 650;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   fail_count;
    int   pending;
    int   sent;

    utf8d_byte_if in_ch();
    utf8d_cp_if   out_ch();

    utf8_lenient_decoder DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    utf8_lenient_decoder_chk u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 11);
    end

    task automatic send_byte(logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(99) < 11) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        sent++;
    endtask

    function automatic logic [BYTE_W-1:0] lead_of(int len);
        logic [BYTE_W-1:0] r;
        r = BYTE_W'($urandom);
        case (len)
            1: r = {1'b0, r[6:0]};
            2: r = {3'b110, r[4:0]};
            3: r = {4'b1110, r[3:0]};
            default: r = {5'b11110, r[2:0]};
        endcase
        return r;
    endfunction

    task automatic send_sequence(int len, bit cut);
        int conts;
        conts = cut ? $urandom_range(len - 2, 0) : len - 1;
        send_byte(lead_of(len));
        repeat (conts) begin
            send_byte({2'b10, 6'($urandom)});
        end
        if (cut) begin
            send_byte(BYTE_W'($urandom_range(255)));
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] directed[$];
        int                pick;
        int                goal;
        directed = {8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF, 8'hC2, 8'hA9,
                    8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
                    8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hC3, 8'h41, 8'hE2, 8'hC3,
                    8'hA9, 8'hF0, 8'hFC};
        sent = 0;
        calm <= 1'b0;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.in_byte <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            send_byte(directed[k]);
        end

        goal = sent + RANDOM_BYTES;
        while (sent < goal) begin
            calm <= (sent > goal - 450) && (sent < goal - 280);
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_sequence($urandom_range(4, 1), 1'b0);
            end else if (pick < 80) begin
                send_sequence($urandom_range(4, 2), 1'b1);
            end else begin
                send_byte(BYTE_W'($urandom_range(255)));
            end
        end
        in_ch.valid <= 1'b0;

        repeat (2) @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
